// ===== rtl/multi_port_block_aggregator_defines.svh =====
// assertion macros for the block aggregator
`ifndef MULTI_PORT_BLOCK_AGGREGATOR_DEFINES_SVH
`define MULTI_PORT_BLOCK_AGGREGATOR_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define MPBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define MPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/mpba_pkg.sv =====
// package: types and constants for the block aggregator
package mpba_pkg;
  localparam int PORT_COUNT_DEF = 3;
  localparam int DIRECT_BYTES_DEF = 512;
  localparam int UPSTREAM_BYTES_DEF = 2048;
  localparam logic [3:0] DETECT_RESET = 4'd3;

  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_UPSTREAM = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    STEP_D0 = 4'd0, STEP_D1 = 4'd1, STEP_D2 = 4'd2, STEP_TAB = 4'd3,
    STEP_DIG0 = 4'd4, STEP_DIG1 = 4'd5, STEP_DIG2 = 4'd6, STEP_DIG3 = 4'd7,
    STEP_CR = 4'd8, STEP_LF = 4'd9, STEP_DATA = 4'd10
  } step_t;

  localparam logic OP_RECV = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [1:0] port_number;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // decimal digit of a count below 10000, position 0 thousands .. 3 units
  function automatic logic [7:0] dec_digit(input logic [9:0] v, input logic [1:0] pos);
    logic [9:0] q;
    begin
      case (pos)
        2'd0: q = v / 10'd1000;
        2'd1: q = (v / 10'd100) % 10'd10;
        2'd2: q = (v / 10'd10) % 10'd10;
        default: q = v % 10'd10;
      endcase
      dec_digit = CH_ZERO + q[7:0];
    end
  endfunction
endpackage

// ===== rtl/mpba_ram.sv =====
// generic single-write, registered-read ram
module mpba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/multi_port_block_aggregator.sv =====
// top level: per-port block assembly, byte stores and packet emitter
// a receive item's result is registered on acceptance; a pull that reads a store
// byte has its result registered after the store read. throughput: one item per cycle
//   while the output is not stalled; any item behind such a pull waits for its read
// reset: synchronous rst clears all port control state and the emitter; the byte
//   stores are not cleared and need no clearing pass
module multi_port_block_aggregator #(
  parameter int PORT_COUNT = mpba_pkg::PORT_COUNT_DEF,
  parameter int DIRECT_BYTES = mpba_pkg::DIRECT_BYTES_DEF,
  parameter int UPSTREAM_BYTES = mpba_pkg::UPSTREAM_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mpba_pkg::in_item_t  in_item,
  output logic                out_valid_o,
  input  logic                out_stall,
  output mpba_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data
);
`include "multi_port_block_aggregator_defines.svh"

  localparam int DW = $clog2(DIRECT_BYTES);
  localparam int UW = $clog2(UPSTREAM_BYTES);
  localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int DAW = $clog2(PORT_COUNT * DIRECT_BYTES);
  localparam int UAW = $clog2(PORT_COUNT * UPSTREAM_BYTES);
  localparam logic [DW:0] DMAX = (DW + 1)'(DIRECT_BYTES - 1);
  localparam logic [UW:0] UMAX = (UW + 1)'(UPSTREAM_BYTES - 1);

  logic [3:0] detect_line_count;

  // per-port control state in flip-flops, byte payload in the two rams
  mpba_pkg::kind_t port_kind [PORT_COUNT];
  logic [3:0]  lines_seen [PORT_COUNT];
  logic        marker_seen [PORT_COUNT];
  logic [DW:0] direct_length [PORT_COUNT];
  logic        direct_ready [PORT_COUNT];
  logic        direct_prev_nl [PORT_COUNT];
  logic [UW:0] upstream_length [PORT_COUNT];
  logic        upstream_ready [PORT_COUNT];
  logic [7:0]  blocks_expected [PORT_COUNT];
  logic [7:0]  blocks_received [PORT_COUNT];
  logic        upstream_prev_nl [PORT_COUNT];
  logic        marker_dash_ok [PORT_COUNT];
  logic [7:0]  marker_number [PORT_COUNT];
  logic        marker_parse_done [PORT_COUNT];

  // emitter
  logic                   emit_active;
  logic [PORT_COUNT-1:0]  emit_mask;
  mpba_pkg::step_t        emit_step;
  logic [PW-1:0]          emit_port;
  logic [UW:0]            emit_index;
  logic [9:0]             emit_count;

  // output register and pending store read
  mpba_pkg::out_item_t res;
  logic                res_valid;
  logic                rd_pend;       // store read issued, byte arrives next cycle
  logic                rd_direct;
  logic                rd_last;

  logic take;
  logic out_free;

  // output register is free when empty or being taken; any item behind a pending read waits
  assign out_free = !res_valid || !out_stall;
  assign in_stall = !out_free || rd_pend;
  assign take = in_valid && !in_stall;

  assign out_valid_o = res_valid;
  assign out_item = res;

  // ---------------- snapshot and next-port search ----------------
  logic [PORT_COUNT-1:0] ready_vec;
  logic [9:0]            ready_count;
  always_comb begin
    ready_vec = '0;
    ready_count = '0;
    for (int p = 0; p < PORT_COUNT; p++) begin
      if (port_kind[p] == mpba_pkg::KIND_DIRECT && direct_ready[p]) begin
        ready_vec[p] = 1'b1;
        ready_count = ready_count + 10'd1;
      end else if (port_kind[p] == mpba_pkg::KIND_UPSTREAM && upstream_ready[p]) begin
        ready_vec[p] = 1'b1;
        ready_count = ready_count + 10'(blocks_expected[p]);
      end
    end
  end

  function automatic logic [UW:0] plen(input int p);
    plen = (port_kind[p] == mpba_pkg::KIND_DIRECT) ? (UW + 1)'(direct_length[p])
                                                   : upstream_length[p];
  endfunction

  // snapshot ports holding bytes; empty ones are skipped by the data search
  logic [PORT_COUNT-1:0] nonempty;
  always_comb begin
    for (int p = 0; p < PORT_COUNT; p++) nonempty[p] = emit_mask[p] && (plen(p) != '0);
  end

  // ---------------- receive / pull processing ----------------
  logic do_recv, do_pull;
  assign do_recv = take && in_item.opcode == mpba_pkg::OP_RECV;
  assign do_pull = take && in_item.opcode == mpba_pkg::OP_PULL;

  logic        d_we, u_we;
  logic [DAW-1:0] d_waddr, d_raddr;
  logic [UAW-1:0] u_waddr, u_raddr;
  logic [7:0]  d_rdata, u_rdata;

  mpba_ram #(.WIDTH(8), .DEPTH(PORT_COUNT * DIRECT_BYTES)) u_dram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(in_item.data_byte),
    .raddr(d_raddr), .rdata(d_rdata)
  );
  mpba_ram #(.WIDTH(8), .DEPTH(PORT_COUNT * UPSTREAM_BYTES)) u_uram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(in_item.data_byte),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  logic [PW-1:0] rp;
  logic          rp_ok;
  logic          nl;
  logic [7:0]    c;
  assign c = in_item.data_byte;
  assign nl = (c == mpba_pkg::CH_NL);
  assign rp_ok = 32'(in_item.port_number) < PORT_COUNT;
  assign rp = PW'(in_item.port_number);

  // pull planning
  logic          pl_valid, pl_last, pl_read, pl_direct, pl_start, pl_finish;
  logic [7:0]    pl_byte;
  logic [PORT_COUNT-1:0] mask_cur, mask_after, clr_vec;
  logic [PW-1:0] sel_port, nport_next;
  logic          sel_found, any_after;
  logic [UW:0]   idx_next;
  mpba_pkg::step_t step_next;
  logic [9:0]    cnt_cur;

  always_comb begin
    pl_valid = 1'b0; pl_last = 1'b0; pl_read = 1'b0; pl_direct = 1'b0;
    pl_byte = '0; pl_start = 1'b0; pl_finish = 1'b0;
    clr_vec = '0;
    sel_port = '0; sel_found = 1'b0; any_after = 1'b0;
    idx_next = emit_index; nport_next = emit_port;
    step_next = emit_step;
    mask_cur = emit_mask;
    cnt_cur = emit_count;
    d_raddr = '0; u_raddr = '0;
    if (!emit_active) begin
      mask_cur = ready_vec;
      cnt_cur = ready_count;
      step_next = mpba_pkg::STEP_D0;
      pl_start = ready_count != '0;
    end
    if (emit_active || pl_start) begin
      pl_valid = 1'b1;
      case (emit_active ? emit_step : mpba_pkg::STEP_D0)
        mpba_pkg::STEP_D0, mpba_pkg::STEP_D1, mpba_pkg::STEP_D2: begin
          pl_byte = mpba_pkg::CH_DASH;
          step_next = mpba_pkg::step_t'((emit_active ? emit_step : mpba_pkg::STEP_D0) + 4'd1);
        end
        mpba_pkg::STEP_TAB: begin
          pl_byte = mpba_pkg::CH_TAB;
          if (cnt_cur >= 10'd1000) step_next = mpba_pkg::STEP_DIG0;
          else if (cnt_cur >= 10'd100) step_next = mpba_pkg::STEP_DIG1;
          else if (cnt_cur >= 10'd10) step_next = mpba_pkg::STEP_DIG2;
          else step_next = mpba_pkg::STEP_DIG3;
        end
        mpba_pkg::STEP_DIG0, mpba_pkg::STEP_DIG1, mpba_pkg::STEP_DIG2,
        mpba_pkg::STEP_DIG3: begin
          pl_byte = mpba_pkg::dec_digit(cnt_cur, emit_step[1:0]);
          step_next = mpba_pkg::step_t'(emit_step + 4'd1);
        end
        mpba_pkg::STEP_CR: begin
          pl_byte = mpba_pkg::CH_CR;
          step_next = mpba_pkg::STEP_LF;
        end
        mpba_pkg::STEP_LF: begin
          pl_byte = mpba_pkg::CH_NL;
          step_next = mpba_pkg::STEP_DATA;
        end
        default: begin
          // data: find the port to send from, empty ones are dropped
          for (int p = PORT_COUNT - 1; p >= 0; p--) begin
            if (32'(p) >= 32'(emit_port) && emit_mask[p]) begin
              if (nonempty[p]) begin
                sel_port = PW'(p);
                sel_found = 1'b1;
              end
            end
          end
          for (int p = 0; p < PORT_COUNT; p++) begin
            if (32'(p) >= 32'(emit_port) && emit_mask[p] &&
                (!sel_found || 32'(p) < 32'(sel_port))) clr_vec[p] = 1'b1;
          end
          if (!sel_found) begin
            pl_valid = 1'b0;
            pl_finish = 1'b1;
          end else begin
            pl_read = 1'b1;
            pl_direct = port_kind[sel_port] == mpba_pkg::KIND_DIRECT;
            d_raddr = DAW'(32'(sel_port) * DIRECT_BYTES + 32'(emit_index[DW-1:0]));
            u_raddr = UAW'(32'(sel_port) * UPSTREAM_BYTES + 32'(emit_index[UW-1:0]));
            idx_next = emit_index + 1'b1;
            if (idx_next >= plen(int'(sel_port))) begin
              clr_vec[sel_port] = 1'b1;
              nport_next = PW'(32'(sel_port) + 1);
              idx_next = '0;
            end else begin
              nport_next = sel_port;
            end
          end
        end
      endcase
      mask_after = mask_cur & ~clr_vec;
      // last byte when stepping into data with nothing left at or after next port
      if (pl_valid && step_next == mpba_pkg::STEP_DATA) begin
        for (int p = 0; p < PORT_COUNT; p++) begin
          if (32'(p) >= 32'(nport_next) && mask_after[p] && plen(p) != '0 &&
              !(pl_read && 32'(p) == 32'(sel_port) && clr_vec[p])) any_after = 1'b1;
        end
        pl_last = !any_after;
      end
    end
    mask_after = mask_cur & ~clr_vec;
  end

  // ---------------- state update ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_line_count <= mpba_pkg::DETECT_RESET;
      for (int p = 0; p < PORT_COUNT; p++) begin
        port_kind[p] <= mpba_pkg::KIND_UNKNOWN;
        lines_seen[p] <= '0; marker_seen[p] <= 1'b0;
        direct_length[p] <= '0; direct_ready[p] <= 1'b0; direct_prev_nl[p] <= 1'b0;
        upstream_length[p] <= '0; upstream_ready[p] <= 1'b0;
        blocks_expected[p] <= '0; blocks_received[p] <= '0; upstream_prev_nl[p] <= 1'b0;
        marker_dash_ok[p] <= 1'b1; marker_number[p] <= '0; marker_parse_done[p] <= 1'b0;
      end
      emit_active <= 1'b0; emit_mask <= '0; emit_step <= mpba_pkg::STEP_D0;
      emit_port <= '0; emit_index <= '0; emit_count <= '0;
      res_valid <= 1'b0; rd_pend <= 1'b0; rd_direct <= 1'b0; rd_last <= 1'b0;
    end else begin
      if (cfg_we) detect_line_count <= cfg_data;
      if (out_free && !rd_pend) res_valid <= 1'b0;
      rd_pend <= 1'b0;
      if (rd_pend) res_valid <= 1'b1;

      if (do_recv) begin
        res_valid <= 1'b1;
        res.out_valid <= 1'b0; res.out_byte <= '0; res.out_last <= 1'b0;
        res.accepted <= 1'b0;
        if (rp_ok) begin
          res.accepted <= 1'b1;
          case (port_kind[rp])
            mpba_pkg::KIND_UNKNOWN: begin
              if (nl) begin
                if (lines_seen[rp] != 4'd15) lines_seen[rp] <= lines_seen[rp] + 4'd1;
                if (marker_seen[rp]) port_kind[rp] <= mpba_pkg::KIND_UPSTREAM;
                else if ((lines_seen[rp] == 4'd15 ? 5'd15 : 5'(lines_seen[rp]) + 5'd1)
                         >= 5'(detect_line_count))
                  port_kind[rp] <= mpba_pkg::KIND_DIRECT;
              end else if (c == mpba_pkg::CH_DASH && lines_seen[rp] == '0) begin
                marker_seen[rp] <= 1'b1;
              end
            end
            mpba_pkg::KIND_DIRECT: begin
              if (direct_ready[rp]) res.accepted <= 1'b0;
              else if (nl && direct_prev_nl[rp]) begin
                if (direct_length[rp] != '0) begin
                  if (direct_length[rp] < DMAX) direct_length[rp] <= direct_length[rp] + 1'b1;
                  direct_ready[rp] <= 1'b1;
                end
              end else begin
                direct_prev_nl[rp] <= nl;
                if (direct_length[rp] < DMAX) direct_length[rp] <= direct_length[rp] + 1'b1;
              end
            end
            default: begin
              if (upstream_ready[rp]) res.accepted <= 1'b0;
              else if (blocks_expected[rp] == '0) begin
                if (nl) begin
                  if ((upstream_length[rp] < UMAX ? upstream_length[rp] + 1'b1
                                                  : upstream_length[rp]) >= (UW + 1)'(5)
                      && (marker_dash_ok[rp] && !(upstream_length[rp] < 3 && c != mpba_pkg::CH_DASH))
                      && marker_number[rp] != '0) begin
                    blocks_expected[rp] <= marker_number[rp];
                    blocks_received[rp] <= '0;
                    upstream_prev_nl[rp] <= 1'b0;
                  end
                  upstream_length[rp] <= '0;
                  marker_dash_ok[rp] <= 1'b1;
                  marker_number[rp] <= '0;
                  marker_parse_done[rp] <= 1'b0;
                end else if (upstream_length[rp] < UMAX) begin
                  upstream_length[rp] <= upstream_length[rp] + 1'b1;
                  if (upstream_length[rp] < 3 && c != mpba_pkg::CH_DASH)
                    marker_dash_ok[rp] <= 1'b0;
                  if (upstream_length[rp] >= 4 && !marker_parse_done[rp]) begin
                    if (c >= mpba_pkg::CH_ZERO && c <= 8'h39) begin
                      if (({2'b0, marker_number[rp]} * 11'd10 + 11'(c - mpba_pkg::CH_ZERO))
                          > 11'd255) marker_number[rp] <= 8'd255;
                      else marker_number[rp] <= 8'(marker_number[rp] * 8'd10 +
                                                   (c - mpba_pkg::CH_ZERO));
                    end else begin
                      marker_parse_done[rp] <= 1'b1;
                    end
                  end
                end
              end else begin
                if (upstream_length[rp] < UMAX) upstream_length[rp] <= upstream_length[rp] + 1'b1;
                if (nl && upstream_prev_nl[rp]) begin
                  blocks_received[rp] <= blocks_received[rp] + 8'd1;
                  if (blocks_received[rp] + 8'd1 >= blocks_expected[rp])
                    upstream_ready[rp] <= 1'b1;
                end
                upstream_prev_nl[rp] <= nl;
              end
            end
          endcase
        end
      end

      if (do_pull) begin
        res.accepted <= 1'b0;
        res.out_valid <= pl_valid;
        res.out_byte <= pl_byte;
        res.out_last <= pl_last;
        res_valid <= !pl_read;
        rd_pend <= pl_read;
        rd_direct <= pl_direct;
        rd_last <= pl_last;
        for (int p = 0; p < PORT_COUNT; p++) begin
          if (clr_vec[p]) begin
            if (port_kind[p] == mpba_pkg::KIND_DIRECT) begin
              direct_length[p] <= '0; direct_ready[p] <= 1'b0; direct_prev_nl[p] <= 1'b0;
            end else begin
              upstream_length[p] <= '0; upstream_ready[p] <= 1'b0;
              blocks_expected[p] <= '0; blocks_received[p] <= '0;
              upstream_prev_nl[p] <= 1'b0;
            end
          end
        end
        if (pl_finish || pl_last) begin
          emit_active <= 1'b0; emit_mask <= '0; emit_step <= mpba_pkg::STEP_D0;
          emit_port <= '0; emit_index <= '0; emit_count <= '0;
        end else if (pl_valid) begin
          emit_active <= 1'b1; emit_mask <= mask_after; emit_count <= cnt_cur;
          emit_step <= step_next; emit_port <= nport_next; emit_index <= idx_next;
        end
      end

      // store byte arrives from the ram
      if (rd_pend) begin
        res.out_byte <= rd_direct ? d_rdata : u_rdata;
        res.out_last <= rd_last;
      end
    end
  end

  // store writes use the length before this item
  always_comb begin
    d_we = 1'b0; u_we = 1'b0;
    d_waddr = DAW'(32'(rp) * DIRECT_BYTES + 32'(direct_length[rp][DW-1:0]));
    u_waddr = UAW'(32'(rp) * UPSTREAM_BYTES + 32'(upstream_length[rp][UW-1:0]));
    if (do_recv && rp_ok) begin
      if (port_kind[rp] == mpba_pkg::KIND_DIRECT && !direct_ready[rp] &&
          direct_length[rp] < DMAX && !(nl && direct_prev_nl[rp] && direct_length[rp] == '0))
        d_we = 1'b1;
      if (port_kind[rp] == mpba_pkg::KIND_UPSTREAM && !upstream_ready[rp] &&
          blocks_expected[rp] != '0 && upstream_length[rp] < UMAX)
        u_we = 1'b1;
    end
  end

  // ---------------- checks ----------------
  `MPBA_ASSERT_NEXT(a_read_lands, rd_pend, res_valid, "store read lost its result")
  `MPBA_ASSERT_IMP(a_no_take_on_read, rd_pend, in_stall, "item taken while store read pending")
  `MPBA_ASSERT_IMP(a_one_result_kind, res_valid, !(res.accepted && res.out_valid),
                   "result carries both receive and pull flags")
endmodule
